>>> rtl/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg: shared types and constants of the block buffer tracker
// Entry layout, request and status codes, sequencer states and the
// request structures that pass between the controller and the entry store.
// ----------------------------------------------------------------------------
package bbt_pkg;

	localparam int ENTRIES    = 64;
	localparam int BLOCK_BITS = 15;
	localparam int PIN_BITS   = 8;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_BITS  = 6;
	localparam int STAT_BITS  = 3;

	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
	localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(ENTRIES - 1);

	typedef enum logic [1:0] {
		OP_ACQUIRE   = 2'd0,
		OP_UNPIN     = 2'd1,
		OP_MARK_DIRTY = 2'd2,
		OP_WRITE_BACK = 2'd3
	} op_t;

	typedef enum logic [STAT_BITS-1:0] {
		STATUS_OK       = 3'd0,
		STATUS_ABSENT   = 3'd1,
		STATUS_FULL     = 3'd2,
		STATUS_UNDERFLOW = 3'd3,
		STATUS_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic                  dirty;
		logic [PIN_BITS-1:0]   pins;
		logic [BLOCK_BITS-1:0] block;
	} entry_t;

	typedef struct packed {
		logic                rd_en;
		logic [IDX_BITS-1:0] rd_addr;
		logic                wr_en;
		logic [IDX_BITS-1:0] wr_addr;
		entry_t              wr_data;
		logic                vld_wr_en;
		logic                vld_wr_val;
	} store_req_t;

	typedef struct packed {
		logic   valid;
		entry_t data;
	} store_rsp_t;

endpackage

>>> rtl/block_buffer_tracker_core.sv
// ----------------------------------------------------------------------------
// block_buffer_tracker_core: tag, pin and dirty tracker of a block buffer pool
// Requests (acquire, unpin, mark dirty, write back) name a disk block; each
// yields one result with status, slot, pin count and fill/flush/release flags.
//
// Input channel: in_valid/in_stall with op, block_number, pin_request.
// Output channel: out_valid/out_stall with status, hit, slot, need_fill,
// need_flush, released, pins_after.
// One transaction at a time: in_stall is high from the accept until the
// result is loaded into the output register. Each request walks all 64
// entries through one tag compare against a registered memory read, so the
// tracker takes no new request until the entry scan and the entry update of
// the one before are through.
// If the receiver stalls, the result holds in the output register and the
// tracker waits in its final step before updating the entry.
// Reset clears all valid bits at once; no clearing pass is needed and the
// block accepts a transaction as soon as reset is released.
// ----------------------------------------------------------------------------
module block_buffer_tracker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic [bbt_pkg::BLOCK_BITS-1:0]      block_number,
	input  logic                                pin_request,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bbt_pkg::STAT_BITS-1:0]       status,
	output logic                                hit,
	output logic [bbt_pkg::SLOT_BITS-1:0]       slot,
	output logic                                need_fill,
	output logic                                need_flush,
	output logic                                released,
	output logic [bbt_pkg::PIN_BITS-1:0]        pins_after
);

	bbt_pkg::store_req_t st_req;
	bbt_pkg::store_rsp_t st_rsp;

	bbt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.block_number (block_number),
		.pin_request  (pin_request),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.hit          (hit),
		.slot         (slot),
		.need_fill    (need_fill),
		.need_flush   (need_flush),
		.released     (released),
		.pins_after   (pins_after),
		.st_req       (st_req),
		.st_rsp       (st_rsp)
	);

	bbt_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.rsp    (st_rsp)
	);

endmodule

>>> rtl/bbt_store.sv
// ----------------------------------------------------------------------------
// bbt_store: entry storage of the block buffer tracker
// Block number, pin count and dirty bit live in a memory with separate read
// and write addresses and a registered read; the per-entry valid bits are
// flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module bbt_store (
	input  logic                clk,
	input  logic                arst_n,
	input  bbt_pkg::store_req_t req,
	output bbt_pkg::store_rsp_t rsp
);

	bbt_pkg::entry_t                 mem [bbt_pkg::ENTRIES];
	logic [bbt_pkg::ENTRIES-1:0]     valid_q;
	bbt_pkg::entry_t                 rd_data_q;
	logic                            rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.vld_wr_en) begin
				valid_q[req.wr_addr] <= req.vld_wr_val;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rsp.valid = rd_valid_q;
	assign rsp.data  = rd_data_q;

endmodule

>>> rtl/bbt_ctrl.sv
// ----------------------------------------------------------------------------
// bbt_ctrl: scan sequencer and update unit of the block buffer tracker
// Walks every entry through one tag compare, remembers the matching entry and
// the lowest free entry, then applies the request and loads the result register.
// ----------------------------------------------------------------------------
module bbt_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic [bbt_pkg::BLOCK_BITS-1:0]      block_number,
	input  logic                                pin_request,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bbt_pkg::STAT_BITS-1:0]       status,
	output logic                                hit,
	output logic [bbt_pkg::SLOT_BITS-1:0]       slot,
	output logic                                need_fill,
	output logic                                need_flush,
	output logic                                released,
	output logic [bbt_pkg::PIN_BITS-1:0]        pins_after,
	output bbt_pkg::store_req_t                 st_req,
	input  bbt_pkg::store_rsp_t                 st_rsp
);

	bbt_pkg::state_t                   state_q;
	bbt_pkg::state_t                   state_d;
	bbt_pkg::op_t                      op_q;
	logic [bbt_pkg::BLOCK_BITS-1:0]    blk_q;
	logic                              preq_q;
	logic [bbt_pkg::IDX_BITS-1:0]      cnt_q;
	logic                              rd_pend_s1;
	logic [bbt_pkg::IDX_BITS-1:0]      rd_idx_s1;
	logic                              found_q;
	logic [bbt_pkg::IDX_BITS-1:0]      hit_idx_q;
	bbt_pkg::entry_t                   hit_ent_q;
	logic                              free_found_q;
	logic [bbt_pkg::IDX_BITS-1:0]      free_idx_q;

	logic                              out_valid_q;
	logic [bbt_pkg::STAT_BITS-1:0]     status_q;
	logic                              hit_q;
	logic [bbt_pkg::SLOT_BITS-1:0]     slot_q;
	logic                              fill_q;
	logic                              flush_q;
	logic                              rel_q;
	logic [bbt_pkg::PIN_BITS-1:0]      pins_q;

	logic                              accept;
	logic                              out_free;
	logic                              fire;
	logic                              match;
	logic [bbt_pkg::PIN_BITS:0]        pin_sum;

	bbt_pkg::status_t                  r_status;
	logic                              r_hit;
	logic [bbt_pkg::IDX_BITS-1:0]      r_idx;
	logic                              r_fill;
	logic                              r_flush;
	logic                              r_rel;
	logic [bbt_pkg::PIN_BITS-1:0]      r_pins;
	logic                              r_wr;
	bbt_pkg::entry_t                   r_ent;
	logic                              r_vld_wr;
	logic                              r_vld_val;

	assign in_stall = (state_q != bbt_pkg::ST_IDLE);
	assign accept   = in_valid && (state_q == bbt_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = (state_q == bbt_pkg::ST_EXEC) && out_free;
	assign match    = rd_pend_s1 && st_rsp.valid && (st_rsp.data.block == blk_q);
	assign pin_sum  = {1'b0, hit_ent_q.pins} + {{bbt_pkg::PIN_BITS{1'b0}}, preq_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			bbt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = bbt_pkg::ST_SCAN;
				end
			end
			bbt_pkg::ST_SCAN: begin
				if (cnt_q == bbt_pkg::IDX_LAST) begin
					state_d = bbt_pkg::ST_DRAIN;
				end
			end
			bbt_pkg::ST_DRAIN: begin
				state_d = bbt_pkg::ST_EXEC;
			end
			bbt_pkg::ST_EXEC: begin
				if (out_free) begin
					state_d = bbt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bbt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		r_status  = bbt_pkg::STATUS_OK;
		r_hit     = 1'b0;
		r_idx     = '0;
		r_fill    = 1'b0;
		r_flush   = 1'b0;
		r_rel     = 1'b0;
		r_pins    = '0;
		r_wr      = 1'b0;
		r_ent     = hit_ent_q;
		r_vld_wr  = 1'b0;
		r_vld_val = 1'b0;
		if (op_q == bbt_pkg::OP_ACQUIRE) begin
			if (found_q) begin
				r_hit = 1'b1;
				r_idx = hit_idx_q;
				r_wr  = 1'b1;
				if (pin_sum[bbt_pkg::PIN_BITS]) begin
					r_ent.pins = bbt_pkg::PIN_MAX;
					r_status   = bbt_pkg::STATUS_OVERFLOW;
				end else begin
					r_ent.pins = pin_sum[bbt_pkg::PIN_BITS-1:0];
				end
				r_pins = r_ent.pins;
			end else if (free_found_q) begin
				r_idx       = free_idx_q;
				r_wr        = 1'b1;
				r_ent.block = blk_q;
				r_ent.pins  = bbt_pkg::PIN_BITS'(preq_q);
				r_ent.dirty = 1'b0;
				r_vld_wr    = 1'b1;
				r_vld_val   = 1'b1;
				r_fill      = 1'b1;
				r_pins      = r_ent.pins;
			end else begin
				r_status = bbt_pkg::STATUS_FULL;
			end
		end else if (!found_q) begin
			r_status = bbt_pkg::STATUS_ABSENT;
		end else begin
			r_hit = 1'b1;
			r_idx = hit_idx_q;
			case (op_q)
				bbt_pkg::OP_UNPIN: begin
					if (hit_ent_q.pins == '0) begin
						r_status = bbt_pkg::STATUS_UNDERFLOW;
					end else begin
						r_wr       = 1'b1;
						r_ent.pins = hit_ent_q.pins - bbt_pkg::PIN_BITS'(1);
					end
				end
				bbt_pkg::OP_MARK_DIRTY: begin
					r_wr        = 1'b1;
					r_ent.dirty = 1'b1;
				end
				bbt_pkg::OP_WRITE_BACK: begin
					r_flush = hit_ent_q.dirty;
					if (hit_ent_q.pins == '0) begin
						r_vld_wr  = 1'b1;
						r_vld_val = 1'b0;
						r_rel     = 1'b1;
					end
				end
				default: begin
					r_wr = 1'b0;
				end
			endcase
			r_pins = r_ent.pins;
		end
	end

	always_comb begin
		st_req            = '0;
		st_req.rd_en      = (state_q == bbt_pkg::ST_SCAN);
		st_req.rd_addr    = cnt_q;
		st_req.wr_addr    = r_idx;
		st_req.wr_data    = r_ent;
		st_req.wr_en      = fire && r_wr;
		st_req.vld_wr_en  = fire && r_vld_wr;
		st_req.vld_wr_val = r_vld_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bbt_pkg::ST_IDLE;
			cnt_q        <= '0;
			rd_pend_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= (state_q == bbt_pkg::ST_SCAN);
			if (accept) begin
				cnt_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == bbt_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + bbt_pkg::IDX_BITS'(1);
			end
			if (match && !found_q) begin
				found_q <= 1'b1;
			end
			if (rd_pend_s1 && !st_rsp.valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (accept) begin
			op_q   <= bbt_pkg::op_t'(op);
			blk_q  <= block_number;
			preq_q <= pin_request;
		end
		if (match && !found_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_ent_q <= st_rsp.data;
		end
		if (rd_pend_s1 && !st_rsp.valid && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (fire) begin
			status_q <= r_status;
			hit_q    <= r_hit;
			slot_q   <= bbt_pkg::SLOT_BITS'(r_idx);
			fill_q   <= r_fill;
			flush_q  <= r_flush;
			rel_q    <= r_rel;
			pins_q   <= r_pins;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign hit        = hit_q;
	assign slot       = slot_q;
	assign need_fill  = fill_q;
	assign need_flush = flush_q;
	assign released   = rel_q;
	assign pins_after = pins_q;

endmodule
